@@ rtl/hgng_pkg.sv @@
package hgng_pkg;

    // Command codes carried in the cmd field of a sample-channel beat
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes
    localparam int unsigned CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] CFG_HP_FORWARD  = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_HP_FEEDBACK = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_OUT_GAIN    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_GATE_LEVEL  = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_HOLD_RELOAD = 3'd4;
    localparam int unsigned CfgDataW = 16;

    // Register reset values
    localparam logic [15:0]        HP_FORWARD_RST  = 16'd46103;
    localparam logic signed [15:0] HP_FEEDBACK_RST = 16'sd13335;
    localparam logic [15:0]        OUT_GAIN_RST    = 16'd11599;
    localparam logic [14:0]        GATE_LEVEL_RST  = 15'd10362;
    localparam logic [7:0]         HOLD_RELOAD_RST = 8'd5;

    // Activity counter load value on a voiced buffer
    localparam logic [2:0] ACTIVITY_LOAD = 3'd5;

    typedef struct packed {
        logic              cmd;
        logic signed [15:0] in_sample;
        logic              last;
    } sample_beat_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic              end_of_buffer;
        logic              voice_active;
        logic [2:0]        activity_count;
    } result_beat_t;

    typedef struct packed {
        logic [15:0]        hp_forward;
        logic signed [15:0] hp_feedback;
        logic [15:0]        out_gain;
        logic [14:0]        gate_level;
        logic [7:0]         hold_reload;
    } cfg_regs_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } item_kind_t;

    // Classified item as it sits in the queue between front and back
    typedef struct packed {
        item_kind_t         kind;
        logic signed [15:0] sample;
        logic               last;
    } queue_entry_t;

endpackage

@@ rtl/hgng_front.sv @@
module hgng_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  hgng_pkg::sample_beat_t   sample_beat,
    output logic                     q_valid,
    output hgng_pkg::queue_entry_t   q_entry,
    input  logic                     q_pop
);

    localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CountW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0]   PtrLast   = PtrW'(DEPTH - 1);
    localparam logic [CountW-1:0] CountFull = CountW'(DEPTH);

    hgng_pkg::queue_entry_t entry_mem [DEPTH];
    hgng_pkg::queue_entry_t entry_in;

    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    // Classify the incoming beat
    always_comb
    begin
        entry_in.kind   = (sample_beat.cmd == hgng_pkg::CMD_TICK) ?
                          hgng_pkg::KIND_TICK : hgng_pkg::KIND_SAMPLE;
        entry_in.sample = sample_beat.in_sample;
        entry_in.last   = sample_beat.last;
    end

    assign sample_stall = (count_reg == CountFull);
    assign push         = sample_valid && !sample_stall;
    assign pop          = q_pop && q_valid;
    assign q_valid      = (count_reg != '0);
    assign q_entry      = entry_mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

@@ rtl/hgng_back.sv @@
module hgng_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hgng_pkg::cfg_regs_t     cfg,
    input  logic                    q_valid,
    input  hgng_pkg::queue_entry_t  q_entry,
    output logic                    q_pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output hgng_pkg::result_beat_t  result_beat
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FWD  = 6'b000010,
        ST_FB   = 6'b000100,
        ST_FILT = 6'b001000,
        ST_GAIN = 6'b010000,
        ST_OUT  = 6'b100000
    } back_state_t;

    localparam logic signed [35:0] FiltBias = 36'sd32767;
    localparam logic signed [35:0] GainBias = 36'sd16383;
    localparam logic signed [15:0] SampleMax = 16'sd32767;

    // Clamp a scaled value to +-32767
    function automatic logic signed [15:0] sat_sample(input logic signed [35:0] q);
        logic signed [15:0] r;
        if (q > 36'sd32767)
        begin
            r = SampleMax;
        end
        else if (q < -36'sd32767)
        begin
            r = -SampleMax;
        end
        else
        begin
            r = q[15:0];
        end
        return r;
    endfunction

    back_state_t state_reg, state_next;

    hgng_pkg::queue_entry_t item_reg;
    hgng_pkg::result_beat_t result_beat_reg;
    logic                   result_valid_reg;

    logic signed [15:0] prev_input_reg;
    logic signed [15:0] prev_output_reg;
    logic signed [15:0] peak_high_reg;
    logic signed [15:0] peak_low_reg;
    logic [7:0]         hold_count_reg;
    logic [2:0]         activity_reg;
    logic               voice_reg;

    logic signed [35:0] prod_reg;
    logic signed [35:0] acc_reg;
    logic signed [15:0] y_reg;

    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] product;
    logic signed [16:0] diff;
    logic signed [35:0] filt_sum;
    logic signed [35:0] filt_q;
    logic signed [15:0] filt_y;
    logic signed [35:0] gain_q;
    logic signed [15:0] gain_y;
    logic signed [16:0] low_ext;
    logic signed [16:0] neg_level;
    logic               loud;
    logic               slot_free;
    logic               take;
    logic [2:0]         tick_activity;

    assign slot_free = !result_valid_reg || !result_stall;
    assign take      = q_valid &&
                       ((state_reg == ST_IDLE) || ((state_reg == ST_OUT) && slot_free));
    assign q_pop     = take;

    assign result_valid = result_valid_reg;
    assign result_beat  = result_beat_reg;

    // Select operands for the shared multiplier
    assign diff = 17'({item_reg.sample[15], item_reg.sample})
                - 17'({prev_input_reg[15], prev_input_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_FWD:
            begin
                mul_a = {diff[16], diff};
                mul_b = $signed({2'b00, cfg.hp_forward});
            end
            ST_FB:
            begin
                mul_a = {{2{prev_output_reg[15]}}, prev_output_reg};
                mul_b = {{2{cfg.hp_feedback[15]}}, cfg.hp_feedback};
            end
            ST_GAIN:
            begin
                mul_a = {{2{y_reg[15]}}, y_reg};
                mul_b = $signed({2'b00, cfg.out_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Sum the filter products, truncate toward zero by 2^15 and clamp
    assign filt_sum = acc_reg + prod_reg;
    assign filt_q   = (filt_sum + (filt_sum[35] ? FiltBias : 36'sd0)) >>> 15;
    assign filt_y   = sat_sample(filt_q);

    // Truncate the gained product toward zero by 2^14 and clamp
    assign gain_q = (prod_reg + (prod_reg[35] ? GainBias : 36'sd0)) >>> 14;
    assign gain_y = sat_sample(gain_q);

    // Gate compare on the buffer's extremes
    assign low_ext   = {peak_low_reg[15], peak_low_reg};
    assign neg_level = -$signed({2'b00, cfg.gate_level});
    assign loud      = (peak_high_reg > $signed({1'b0, cfg.gate_level}))
                     || (low_ext < neg_level);

    assign tick_activity = (activity_reg >= 3'd2) ? activity_reg - 3'd1 : 3'd0;

    // Sequence one item through the shared multiplier; a tick goes straight to ST_OUT
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = (q_entry.kind == hgng_pkg::KIND_TICK) ? ST_OUT : ST_FWD;
                end
            end
            ST_FWD:  state_next = ST_FB;
            ST_FB:   state_next = ST_FILT;
            ST_FILT: state_next = ST_GAIN;
            ST_GAIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    if (take)
                    begin
                        state_next = (q_entry.kind == hgng_pkg::KIND_TICK) ?
                                     ST_OUT : ST_FWD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold filter, peak, gate and activity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            prev_input_reg   <= '0;
            prev_output_reg  <= '0;
            peak_high_reg    <= '0;
            peak_low_reg     <= '0;
            hold_count_reg   <= '0;
            activity_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_FILT)
            begin
                prev_input_reg  <= item_reg.sample;
                prev_output_reg <= filt_y;
                if (filt_y >= peak_high_reg)
                begin
                    peak_high_reg <= filt_y;
                end
                if (filt_y < peak_low_reg)
                begin
                    peak_low_reg <= filt_y;
                end
            end

            if ((state_reg == ST_GAIN) && item_reg.last)
            begin
                if (loud)
                begin
                    hold_count_reg <= cfg.hold_reload;
                    activity_reg   <= hgng_pkg::ACTIVITY_LOAD;
                end
                else if (hold_count_reg != '0)
                begin
                    hold_count_reg <= hold_count_reg - 8'd1;
                    activity_reg   <= hgng_pkg::ACTIVITY_LOAD;
                end
                peak_high_reg <= '0;
                peak_low_reg  <= '0;
            end

            if ((state_reg == ST_OUT) && slot_free)
            begin
                result_valid_reg <= 1'b1;
                if (item_reg.kind == hgng_pkg::KIND_TICK)
                begin
                    activity_reg <= tick_activity;
                end
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Carry payload through the sequence
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= q_entry;
        end

        // Hold the gain product while the result slot is busy
        if (state_reg != ST_OUT)
        begin
            prod_reg <= product;
        end

        if (state_reg == ST_FB)
        begin
            acc_reg <= prod_reg;
        end

        if (state_reg == ST_FILT)
        begin
            y_reg <= filt_y;
        end

        if (state_reg == ST_GAIN)
        begin
            voice_reg <= item_reg.last && (loud || (hold_count_reg != '0));
        end

        if ((state_reg == ST_OUT) && slot_free)
        begin
            if (item_reg.kind == hgng_pkg::KIND_TICK)
            begin
                result_beat_reg.out_sample     <= '0;
                result_beat_reg.end_of_buffer  <= 1'b0;
                result_beat_reg.voice_active   <= 1'b0;
                result_beat_reg.activity_count <= tick_activity;
            end
            else
            begin
                result_beat_reg.out_sample     <= gain_y;
                result_beat_reg.end_of_buffer  <= item_reg.last;
                result_beat_reg.voice_active   <= voice_reg;
                result_beat_reg.activity_count <= activity_reg;
            end
        end
    end

endmodule

@@ rtl/highpass_gain_noise_gate_core.sv @@
// A sample beat leaves the queue and steps through FWD, FB, FILT, GAIN and OUT, where
// its result is registered; a tick beat goes straight to OUT. The single shared 18x18
// multiplier forms the two filter products and the gain product in turn; a new item
// is taken only in IDLE or OUT. One tick per cycle while results are not stalled. A queue
// of QUEUE_DEPTH beats separates input acceptance from the back end. Reset (rst_n low,
// asynchronous) empties the queue, clears filter and gate state, loads register defaults.
module highpass_gain_noise_gate_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  hgng_pkg::sample_beat_t                 sample_beat,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output hgng_pkg::result_beat_t                 result_beat,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hgng_pkg::CfgIndexW-1:0]         cfg_index,
    input  logic [hgng_pkg::CfgDataW-1:0]          cfg_data
);

    hgng_pkg::cfg_regs_t    cfg_reg;
    hgng_pkg::queue_entry_t q_entry;
    logic                   q_valid;
    logic                   q_pop;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hp_forward  <= hgng_pkg::HP_FORWARD_RST;
            cfg_reg.hp_feedback <= hgng_pkg::HP_FEEDBACK_RST;
            cfg_reg.out_gain    <= hgng_pkg::OUT_GAIN_RST;
            cfg_reg.gate_level  <= hgng_pkg::GATE_LEVEL_RST;
            cfg_reg.hold_reload <= hgng_pkg::HOLD_RELOAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hgng_pkg::CFG_HP_FORWARD:  cfg_reg.hp_forward  <= cfg_data;
                hgng_pkg::CFG_HP_FEEDBACK: cfg_reg.hp_feedback <= $signed(cfg_data);
                hgng_pkg::CFG_OUT_GAIN:    cfg_reg.out_gain    <= cfg_data;
                hgng_pkg::CFG_GATE_LEVEL:  cfg_reg.gate_level  <= cfg_data[14:0];
                hgng_pkg::CFG_HOLD_RELOAD: cfg_reg.hold_reload <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    hgng_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_beat  (sample_beat),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    hgng_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

endmodule

@@ rtl/hgng_checker.sv @@
module hgng_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   result_valid,
    input logic                   result_stall,
    input hgng_pkg::result_beat_t result_beat
);

    // A stalled result beat stays and holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_beat))
    else $error("result beat changed while stalled");

    // Voice decision only on a beat that closes a buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_beat.end_of_buffer |-> !result_beat.voice_active)
    else $error("voice_active set outside end of buffer");

    // A voiced buffer reloads the activity counter
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.voice_active |-> result_beat.activity_count == 3'd5)
    else $error("voiced buffer without activity reload");

    // Activity stays within its range and the sample never reaches the negative rail
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_beat.activity_count <= 3'd5)
                         && (result_beat.out_sample != 16'sh8000))
    else $error("result field out of range");

endmodule

bind highpass_gain_noise_gate_core hgng_checker u_hgng_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import hgng_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BEATS_PER_PHASE = 250;
    localparam int RANDOM_PHASES = 5;
    localparam int DRAIN_CYCLES = 12;
    localparam int SAMPLE_LIMIT = 32767;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURSTY
    } stall_style_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    sample_beat_t sample_beat = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_beat_t result_beat;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // Shadow copy of the registers and the filter/gate state
    cfg_regs_t reg_shadow;
    logic signed [15:0] last_input = '0;
    logic signed [15:0] last_filtered = '0;
    logic signed [15:0] buf_peak = '0;
    logic signed [15:0] buf_trough = '0;
    logic [7:0] hold_left = '0;
    logic [2:0] activity_left = '0;

    result_beat_t gated_results_due[$];
    int mismatches = 0;
    int beats_sent = 0;
    int cycle_count = 0;

    stall_style_e stall_style = STALL_NONE;
    logic stall_phase = 1'b0;
    int stall_run = 0;
    bit gaps_on = 1'b0;
    int burst_left = 0;

    highpass_gain_noise_gate_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_beat(sample_beat),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_beat(result_beat),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Divide by a power of two with truncation toward zero, then clamp
    function automatic int trunc_clamp(longint acc, int sh);
        longint q;
        q = (acc >= 0) ? (acc >>> sh) : -((-acc) >>> sh);
        if (q > SAMPLE_LIMIT)
            q = SAMPLE_LIMIT;
        if (q < -SAMPLE_LIMIT)
            q = -SAMPLE_LIMIT;
        return int'(q);
    endfunction

    // Advance the shadow state by one beat and queue the result it produces
    task automatic predict_gated_result(input sample_beat_t b);
        int x;
        int y;
        int gained;
        int lvl;
        longint acc;
        logic voice;
        result_beat_t r;
        r = '0;
        voice = 1'b0;
        if (b.cmd == CMD_TICK) begin
            activity_left = (activity_left >= 3'd2) ? activity_left - 3'd1 : 3'd0;
        end
        else begin
            x = $signed(b.in_sample);
            acc = longint'(x - int'($signed(last_input))) * longint'({1'b0, reg_shadow.hp_forward})
                + longint'($signed(last_filtered)) * longint'($signed(reg_shadow.hp_feedback));
            y = trunc_clamp(acc, 15);
            last_input = b.in_sample;
            last_filtered = 16'(y);
            if (y >= int'($signed(buf_peak)))
                buf_peak = 16'(y);
            if (y < int'($signed(buf_trough)))
                buf_trough = 16'(y);
            gained = trunc_clamp(longint'(y) * longint'({1'b0, reg_shadow.out_gain}), 14);
            r.out_sample = 16'(gained);
            if (b.last) begin
                r.end_of_buffer = 1'b1;
                lvl = int'({1'b0, reg_shadow.gate_level});
                if (int'($signed(buf_peak)) > lvl || int'($signed(buf_trough)) < -lvl) begin
                    hold_left = reg_shadow.hold_reload;
                    voice = 1'b1;
                end
                else if (hold_left != 8'd0) begin
                    hold_left = hold_left - 8'd1;
                    voice = 1'b1;
                end
                if (voice)
                    activity_left = ACTIVITY_LOAD;
                buf_peak = '0;
                buf_trough = '0;
            end
        end
        r.voice_active = voice;
        r.activity_count = activity_left;
        gated_results_due = {gated_results_due, r};
    endtask

    // Predict on every accepted input beat
    always @(posedge clk) begin
        if (rst_n && sample_valid && !sample_stall)
            predict_gated_result(sample_beat);
    end

    // Compare every accepted result beat with the oldest prediction
    always @(posedge clk) begin
        result_beat_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (gated_results_due.size() == 0) begin
                $error("result beat with nothing pending: %p", result_beat);
                mismatches++;
            end
            else begin
                want = gated_results_due.pop_front();
                if (result_beat.out_sample !== want.out_sample) begin
                    $error("out_sample: expected %0d, got %0d",
                           want.out_sample, result_beat.out_sample);
                    mismatches++;
                end
                if (result_beat.end_of_buffer !== want.end_of_buffer) begin
                    $error("end_of_buffer: expected %0b, got %0b",
                           want.end_of_buffer, result_beat.end_of_buffer);
                    mismatches++;
                end
                if (result_beat.voice_active !== want.voice_active) begin
                    $error("voice_active: expected %0b, got %0b",
                           want.voice_active, result_beat.voice_active);
                    mismatches++;
                end
                if (result_beat.activity_count !== want.activity_count) begin
                    $error("activity_count: expected %0d, got %0d",
                           want.activity_count, result_beat.activity_count);
                    mismatches++;
                end
            end
        end
    end

    // Receiver back-pressure pattern
    always @(negedge clk) begin
        case (stall_style)
            STALL_NONE:
                result_stall = 1'b0;
            STALL_RANDOM:
                result_stall = ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_run == 0) begin
                    stall_phase = !stall_phase;
                    stall_run = stall_phase ? $urandom_range(1, 12) : $urandom_range(1, 10);
                end
                stall_run--;
                result_stall = stall_phase;
            end
        endcase
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one input beat, with a random gap at the start of each burst when gaps are on
    task automatic send_beat(input logic cmd, input logic [15:0] smp, input logic last);
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge clk);
                sample_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        sample_valid = 1'b1;
        sample_beat.cmd = cmd;
        sample_beat.in_sample = smp;
        sample_beat.last = last;
        do
            @(posedge clk);
        while (sample_stall);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_results_done();
        @(negedge clk);
        sample_valid = 1'b0;
        while (gated_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_HP_FORWARD:  reg_shadow.hp_forward = data;
            CFG_HP_FEEDBACK: reg_shadow.hp_feedback = data;
            CFG_OUT_GAIN:    reg_shadow.out_gain = data;
            CFG_GATE_LEVEL:  reg_shadow.gate_level = data[14:0];
            CFG_HOLD_RELOAD: reg_shadow.hold_reload = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(input int amp);
        if (amp >= SAMPLE_LIMIT)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    // One well-formed buffer: samples within +-amp (any value at full scale), last flag on the final one
    task automatic send_buffer(input int len, input int amp);
        for (int i = 0; i < len; i++)
            send_beat(CMD_SAMPLE, pick_sample(amp), i == len - 1);
    endtask

    // Full-scale steps, activity decay down to zero, hold at reset settings
    task automatic test_defaults_directed();
        stall_style = STALL_RANDOM;
        send_beat(CMD_SAMPLE, 16'sd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd32767, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd32768, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd32767, 1'b1);
        repeat (6)
            send_beat(CMD_TICK, 16'hFFFF, 1'b1);
        send_beat(CMD_SAMPLE, -16'sd32768, 1'b1);
        send_beat(CMD_TICK, 16'h0000, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd1, 1'b1);
        send_beat(CMD_SAMPLE, -16'sd1, 1'b1);
        repeat (3)
            send_beat(CMD_SAMPLE, 16'sd0, 1'b1);
        wait_results_done();
    endtask

    // Register extremes, masking of wide data and writes to unused indexes
    task automatic test_register_extremes();
        stall_style = STALL_BURSTY;
        write_register(CFG_HP_FORWARD, 16'hFFFF);
        write_register(CFG_HP_FEEDBACK, 16'h7FFF);
        write_register(CFG_OUT_GAIN, 16'hFFFF);
        write_register(CFG_GATE_LEVEL, 16'h7FFF);
        write_register(CFG_HOLD_RELOAD, 16'h00FF);
        send_beat(CMD_SAMPLE, 16'sd32767, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd32768, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd32767, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd0, 1'b1);
        send_beat(CMD_TICK, 16'h5555, 1'b0);
        wait_results_done();

        write_register(CFG_HP_FORWARD, 16'h0000);
        write_register(CFG_HP_FEEDBACK, 16'h8000);
        write_register(CFG_OUT_GAIN, 16'h0000);
        write_register(CFG_GATE_LEVEL, 16'h0000);
        write_register(CFG_HOLD_RELOAD, 16'h0000);
        send_buffer(4, SAMPLE_LIMIT);
        send_beat(CMD_SAMPLE, 16'sd0, 1'b1);
        wait_results_done();

        for (int i = CFG_HOLD_RELOAD + 1; i < (1 << CfgIndexW); i++)
            write_register(CfgIndexW'(i), 16'hFFFF);
        write_register(CFG_GATE_LEVEL, 16'hFFFF);
        write_register(CFG_HOLD_RELOAD, 16'hFF00);
        write_register(CFG_HP_FORWARD, 16'h8000);
        write_register(CFG_HP_FEEDBACK, 16'hC000);
        write_register(CFG_OUT_GAIN, 16'h4000);
        send_buffer(3, SAMPLE_LIMIT);
        send_beat(CMD_SAMPLE, -16'sd32768, 1'b1);
        wait_results_done();
    endtask

    // Loud buffer reloads the hold, quiet buffers spend it, ticks decay activity
    task automatic test_gate_hold_decay();
        stall_style = STALL_RANDOM;
        write_register(CFG_HP_FORWARD, 16'h8000);
        write_register(CFG_HP_FEEDBACK, 16'h6000);
        write_register(CFG_OUT_GAIN, 16'h4000);
        write_register(CFG_GATE_LEVEL, 16'd2000);
        write_register(CFG_HOLD_RELOAD, 16'd3);
        send_beat(CMD_SAMPLE, 16'sd0, 1'b0);
        send_beat(CMD_SAMPLE, 16'sd8000, 1'b0);
        send_beat(CMD_SAMPLE, -16'sd8000, 1'b1);
        for (int b = 0; b < 6; b++) begin
            wait_results_done();
            send_buffer(2, 0);
            if (b % 2 == 1)
                repeat (2)
                    send_beat(CMD_TICK, 16'($urandom), 1'($urandom));
        end
        wait_results_done();
    endtask

    // Mostly well-formed buffers of mixed loudness, with ticks and stray beats
    task automatic test_random_buffers();
        int phase_start;
        int pick;
        int amp;
        int lvl;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_done();
            case (phase)
                0, 4:
                begin
                    write_register(CFG_HP_FORWARD, 16'($urandom_range(40000, 60000)));
                    write_register(CFG_HP_FEEDBACK, 16'($urandom_range(0, 30000)));
                    write_register(CFG_OUT_GAIN, 16'($urandom_range(8000, 30000)));
                    write_register(CFG_GATE_LEVEL, 16'($urandom_range(500, 12000)));
                    write_register(CFG_HOLD_RELOAD, 16'($urandom_range(0, 6)));
                end
                1:
                begin
                    write_register(CFG_HP_FORWARD, 16'($urandom));
                    write_register(CFG_HP_FEEDBACK, 16'($urandom));
                    write_register(CFG_OUT_GAIN, 16'($urandom));
                    write_register(CFG_GATE_LEVEL, 16'($urandom));
                    write_register(CFG_HOLD_RELOAD, 16'($urandom));
                end
                2:
                begin
                    write_register(CFG_HP_FORWARD, 16'hFFFF);
                    write_register(CFG_HP_FEEDBACK, 16'h8000);
                    write_register(CFG_OUT_GAIN, 16'hFFFF);
                    write_register(CFG_GATE_LEVEL, 16'($urandom_range(0, 4000)));
                    write_register(CFG_HOLD_RELOAD, 16'h00FF);
                end
                default:
                begin
                    write_register(CFG_HP_FORWARD, 16'h0000);
                    write_register(CFG_HP_FEEDBACK, 16'h7FFF);
                    write_register(CFG_OUT_GAIN, 16'($urandom));
                    write_register(CFG_GATE_LEVEL, 16'h0000);
                    write_register(CFG_HOLD_RELOAD, 16'h0000);
                end
            endcase
            // the last phase runs with no idling on either side
            stall_style = (phase == RANDOM_PHASES - 1) ? STALL_NONE
                        : (phase % 2 == 0) ? STALL_RANDOM : STALL_BURSTY;
            gaps_on = (phase != RANDOM_PHASES - 1) && (phase != 2);
            lvl = reg_shadow.gate_level;
            phase_start = beats_sent;
            while (beats_sent - phase_start < RANDOM_BEATS_PER_PHASE) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_beat(1'($urandom), 16'($urandom), 1'($urandom));
                end
                else if (pick <= 3) begin
                    repeat ($urandom_range(1, 3))
                        send_beat(CMD_TICK, 16'($urandom), 1'($urandom));
                end
                else if (pick == 4) begin
                    // broken buffer: no last flag, merges into the next one
                    repeat ($urandom_range(1, 4))
                        send_beat(CMD_SAMPLE, 16'($urandom), 1'b0);
                end
                else begin
                    case ($urandom_range(0, 2))
                        0: amp = lvl / 4;
                        1: amp = lvl;
                        default: amp = SAMPLE_LIMIT;
                    endcase
                    send_buffer($urandom_range(1, 10), amp);
                end
                if ($urandom_range(0, 29) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial begin
        reg_shadow.hp_forward = HP_FORWARD_RST;
        reg_shadow.hp_feedback = HP_FEEDBACK_RST;
        reg_shadow.out_gain = OUT_GAIN_RST;
        reg_shadow.gate_level = GATE_LEVEL_RST;
        reg_shadow.hold_reload = HOLD_RELOAD_RST;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        test_defaults_directed();
        test_register_extremes();
        test_gate_hold_decay();
        test_random_buffers();

        // drain, then watch for stray result beats
        wait_results_done();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
